// File: rtl/remote_button_frame_change_detect_defines.svh
// Assertion macros for the button frame change detector.
// The first form checks a consequent in the same cycle, the second in the next cycle.
`ifndef REMOTE_BUTTON_FRAME_CHANGE_DETECT_DEFINES_SVH
`define REMOTE_BUTTON_FRAME_CHANGE_DETECT_DEFINES_SVH
`ifndef SYNTHESIS
`define RBFCD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rbfcd assertion failed");
`define RBFCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rbfcd assertion failed");
`else
`define RBFCD_ASSERT_NOW(label, clk, rst, ante, cons)
`define RBFCD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/rbfcd_pkg.sv
`timescale 1ns / 1ps
package rbfcd_pkg;

   localparam int NumButtons   = 38;
   localparam int IdxBits      = $clog2(NumButtons);
   localparam int TimeBits     = 32;
   localparam int NumWords     = 3;
   localparam int BassLen      = 12;
   localparam int ChordLen     = 12;
   localparam int ToneLen      = 14;
   localparam int DebounceBits = 16;
   localparam int CntBits      = 4;

   typedef logic [IdxBits-1:0]      idx_type;
   typedef logic [TimeBits-1:0]     ms_type;
   typedef logic [CntBits-1:0]      cnt_type;
   typedef logic [DebounceBits-1:0] debounce_type;
   typedef logic [15:0]             flag_word_type;

   localparam idx_type      LastIdx       = idx_type'(NumButtons - 1);
   localparam cnt_type      FrameBytes    = cnt_type'(6);
   localparam cnt_type      CntMax        = cnt_type'(15);
   localparam debounce_type DebounceReset = debounce_type'(20);

   localparam logic ModeByte   = 1'b0;
   localparam logic ModeEnd    = 1'b1;
   localparam logic KindEvent  = 1'b0;
   localparam logic KindStatus = 1'b1;

   typedef struct packed {
      logic    kind;
      idx_type button_index;
      logic    active;
      logic    frame_ok;
      logic    last;
   } rsp_word_type;

endpackage

// File: rtl/rbfcd_req_if.sv
`timescale 1ns / 1ps
interface rbfcd_req_if;
   logic                   valid;
   logic                   ready;
   logic                   mode;
   logic [7:0]             data_byte;
   logic [31:0]            now_ms;

   modport source (output valid, output mode, output data_byte, output now_ms, input ready);
   modport sink (input valid, input mode, input data_byte, input now_ms, output ready);
endinterface

// File: rtl/rbfcd_rsp_if.sv
`timescale 1ns / 1ps
interface rbfcd_rsp_if;
   logic                     valid;
   logic                     ready;
   logic                     kind;
   rbfcd_pkg::idx_type       button_index;
   logic                     active;
   logic                     frame_ok;
   logic                     last;

   modport source (output valid, output kind, output button_index, output active,
                   output frame_ok, output last, input ready);
   modport sink (input valid, input kind, input button_index, input active,
                 input frame_ok, input last, output ready);
endinterface

// File: rtl/rbfcd_csr_if.sv
`timescale 1ns / 1ps
interface rbfcd_csr_if;
   logic                      valid;
   logic                      ready;
   rbfcd_pkg::debounce_type   data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: rtl/remote_button_frame_change_detect.sv
// Bytes are taken only in ST_IDLE and give no word; a good frame's end starts a scan of 38 buttons.
// A changed button goes through ST_READ (toggle-time memory read) and ST_EVAL (compare, then
// write back if debounce passes); an unchanged one only through ST_READ. Output stalls hold ST_EVAL.
// A short or long frame goes through ST_STATUS to its registered status word, held by output stalls.
// Synchronous active-high reset clears control state, flag words and the per-button valid
// bits, so every toggle time reads as zero until it is first written.
`timescale 1ns / 1ps
`include "remote_button_frame_change_detect_defines.svh"

module remote_button_frame_change_detect (
   input  logic          clock,
   input  logic          reset,
   rbfcd_req_if.sink     req_bus,
   rbfcd_rsp_if.source   rsp_bus,
   rbfcd_csr_if.sink     csr_bus
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_STATUS
   } state_type;

   state_type                 state_ff, state_in;
   rbfcd_pkg::idx_type        idx_ff, idx_in;
   rbfcd_pkg::cnt_type        cnt_ff, cnt_in;
   rbfcd_pkg::ms_type         now_ff, now_in;
   rbfcd_pkg::debounce_type   debounce_ff, debounce_in;
   logic                      ok_ff, ok_in;
   rbfcd_pkg::flag_word_type  new_words_ff [rbfcd_pkg::NumWords];
   rbfcd_pkg::flag_word_type  new_words_in [rbfcd_pkg::NumWords];
   rbfcd_pkg::flag_word_type  cur_words_ff [rbfcd_pkg::NumWords];
   rbfcd_pkg::flag_word_type  cur_words_in [rbfcd_pkg::NumWords];
   logic [rbfcd_pkg::NumButtons-1:0] valid_ff, valid_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rbfcd_pkg::rsp_word_type   rsp_word_ff, rsp_word_in;

   // Toggle-time memory, one entry per button, registered read port.
   rbfcd_pkg::ms_type         toggle_mem [rbfcd_pkg::NumButtons];
   rbfcd_pkg::ms_type         rd_data_ff;
   logic                      rd_valid_ff;
   logic                      rd_en;
   logic                      wr_en;

   logic [rbfcd_pkg::NumButtons-1:0] new_bits;
   logic [rbfcd_pkg::NumButtons-1:0] diff_bits;
   rbfcd_pkg::ms_type         last_time;
   rbfcd_pkg::ms_type         elapsed;
   logic                      debounce_ok;
   logic                      out_free;
   logic                      req_fire;

   assign new_bits = {new_words_ff[2][rbfcd_pkg::ToneLen-1:0],
                      new_words_ff[1][rbfcd_pkg::ChordLen-1:0],
                      new_words_ff[0][rbfcd_pkg::BassLen-1:0]};
   assign diff_bits = new_bits ^ {cur_words_ff[2][rbfcd_pkg::ToneLen-1:0],
                                  cur_words_ff[1][rbfcd_pkg::ChordLen-1:0],
                                  cur_words_ff[0][rbfcd_pkg::BassLen-1:0]};

   assign last_time   = rd_valid_ff ? rd_data_ff : '0;
   assign elapsed     = now_ff - last_time;
   assign debounce_ok = elapsed >= rbfcd_pkg::ms_type'(debounce_ff);

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.kind         = rsp_word_ff.kind;
   assign rsp_bus.button_index = rsp_word_ff.button_index;
   assign rsp_bus.active       = rsp_word_ff.active;
   assign rsp_bus.frame_ok     = rsp_word_ff.frame_ok;
   assign rsp_bus.last         = rsp_word_ff.last;

   always_comb begin
      logic advance;
      state_in     = state_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      now_in       = now_ff;
      ok_in        = ok_ff;
      new_words_in = new_words_ff;
      cur_words_in = cur_words_ff;
      valid_in     = valid_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      debounce_in  = debounce_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      advance      = 1'b0;

      if (csr_bus.valid) begin
         debounce_in = csr_bus.data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_bus.mode == rbfcd_pkg::ModeByte) begin
                  if (cnt_ff < rbfcd_pkg::FrameBytes) begin
                     if (cnt_ff[0]) begin
                        new_words_in[cnt_ff[2:1]][15:8] = req_bus.data_byte;
                     end else begin
                        new_words_in[cnt_ff[2:1]][7:0] = req_bus.data_byte;
                     end
                  end
                  if (cnt_ff != rbfcd_pkg::CntMax) begin
                     cnt_in = cnt_ff + 1'b1;
                  end
               end else begin
                  cnt_in = '0;
                  if (cnt_ff == rbfcd_pkg::FrameBytes) begin
                     now_in   = req_bus.now_ms[rbfcd_pkg::TimeBits-1:0];
                     idx_in   = '0;
                     state_in = ST_READ;
                  end else begin
                     ok_in    = 1'b0;
                     state_in = ST_STATUS;
                  end
               end
            end
         end
         ST_READ: begin
            // Only changed buttons need their toggle time.
            if (diff_bits[idx_ff]) begin
               rd_en    = 1'b1;
               state_in = ST_EVAL;
            end else begin
               advance = 1'b1;
            end
         end
         ST_EVAL: begin
            if (!debounce_ok) begin
               advance = 1'b1;
            end else if (out_free) begin
               wr_en                    = 1'b1;
               valid_in[idx_ff]         = 1'b1;
               rsp_valid_in             = 1'b1;
               rsp_word_in.kind         = rbfcd_pkg::KindEvent;
               rsp_word_in.button_index = idx_ff;
               rsp_word_in.active       = new_bits[idx_ff];
               rsp_word_in.frame_ok     = 1'b1;
               rsp_word_in.last         = 1'b0;
               advance                  = 1'b1;
            end
         end
         ST_STATUS: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_word_in.kind         = rbfcd_pkg::KindStatus;
               rsp_word_in.button_index = '0;
               rsp_word_in.active       = 1'b0;
               rsp_word_in.frame_ok     = ok_ff;
               rsp_word_in.last         = 1'b1;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (advance) begin
         if (idx_ff == rbfcd_pkg::LastIdx) begin
            // Current words follow the new frame even where debounce held a change back.
            cur_words_in = new_words_ff;
            ok_in        = 1'b1;
            state_in     = ST_STATUS;
         end else begin
            idx_in   = idx_ff + 1'b1;
            state_in = ST_READ;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         debounce_ff  <= rbfcd_pkg::DebounceReset;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int w = 0; w < rbfcd_pkg::NumWords; w++) begin
            new_words_ff[w] <= '0;
            cur_words_ff[w] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         debounce_ff  <= debounce_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         new_words_ff <= new_words_in;
         cur_words_ff <= cur_words_in;
      end
      idx_ff      <= idx_in;
      now_ff      <= now_in;
      ok_ff       <= ok_in;
      rsp_word_ff <= rsp_word_in;
   end

   // A read and a write of one entry never overlap: each button is read once per scan,
   // and its write back happens before the scan moves on.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff  <= toggle_mem[idx_ff];
         rd_valid_ff <= valid_ff[idx_ff];
      end
      if (wr_en) begin
         toggle_mem[idx_ff] <= now_ff;
      end
   end

   `RBFCD_ASSERT_NOW(a_event_fields, clock, reset,
      rsp_valid_ff && (rsp_word_ff.kind == rbfcd_pkg::KindEvent),
      rsp_word_ff.frame_ok && !rsp_word_ff.last)
   `RBFCD_ASSERT_NOW(a_count_cleared_in_scan, clock, reset,
      state_ff != ST_IDLE, cnt_ff == '0)
   `RBFCD_ASSERT_NEXT(a_write_marks_valid, clock, reset,
      wr_en, valid_ff[$past(idx_ff)])

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
module testbench;

   localparam int CycleLimit   = 400000;
   localparam int SettleCycles = 12;
   localparam int DrainCycles  = 120;

   typedef struct {
      logic        mode;
      logic [7:0]  data_byte;
      logic [31:0] now_ms;
   } req_word_type;

   logic clock = 1'b0;
   logic reset;

   rbfcd_req_if req_bus ();
   rbfcd_rsp_if rsp_bus ();
   rbfcd_csr_if csr_bus ();

   remote_button_frame_change_detect u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #1 clock = ~clock;

   // Words waiting to be sent and words the block owes us.
   req_word_type            frame_items[$];
   rbfcd_pkg::rsp_word_type expected_words[$];
   int                      error_count = 0;
   int                      cycle_count = 0;

   // Shadow copy of the block's state.
   rbfcd_pkg::debounce_type  debounce_ms;
   rbfcd_pkg::flag_word_type new_words[rbfcd_pkg::NumWords];
   rbfcd_pkg::flag_word_type cur_words[rbfcd_pkg::NumWords];
   rbfcd_pkg::cnt_type       byte_count;
   rbfcd_pkg::ms_type        toggle_ms[rbfcd_pkg::NumButtons];

   // Stimulus bookkeeping.
   rbfcd_pkg::ms_type        wall_ms;
   logic [7:0]               last_frame[6];

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      error_count++;
   endtask

   // Updates the shadow state for one accepted word and queues the words it causes.
   function automatic void predict_frame_word(input req_word_type item);
      int                      base;
      int                      len;
      int                      b;
      logic                    oldb;
      logic                    newb;
      rbfcd_pkg::ms_type       now;
      rbfcd_pkg::ms_type       elapsed;
      rbfcd_pkg::rsp_word_type rsp;
      now = rbfcd_pkg::ms_type'(item.now_ms);
      if (item.mode == rbfcd_pkg::ModeByte) begin
         if (byte_count < rbfcd_pkg::FrameBytes) begin
            if (byte_count[0]) begin
               new_words[byte_count >> 1][15:8] = item.data_byte;
            end else begin
               new_words[byte_count >> 1][7:0] = item.data_byte;
            end
         end
         if (byte_count < rbfcd_pkg::CntMax) begin
            byte_count++;
         end
      end else begin
         rsp.kind = rbfcd_pkg::KindStatus;
         rsp.button_index = '0;
         rsp.active = 1'b0;
         rsp.last = 1'b1;
         if (byte_count != rbfcd_pkg::FrameBytes) begin
            rsp.frame_ok = 1'b0;
         end else begin
            base = 0;
            for (int g = 0; g < rbfcd_pkg::NumWords; g++) begin
               len = (g == 0) ? rbfcd_pkg::BassLen
                              : ((g == 1) ? rbfcd_pkg::ChordLen : rbfcd_pkg::ToneLen);
               for (int i = 0; i < len; i++) begin
                  oldb = cur_words[g][i];
                  newb = new_words[g][i];
                  b = base + i;
                  elapsed = now - toggle_ms[b];
                  if (oldb != newb && elapsed >= rbfcd_pkg::ms_type'(debounce_ms)) begin
                     toggle_ms[b] = now;
                     expected_words.push_back('{kind: rbfcd_pkg::KindEvent,
                                                button_index: rbfcd_pkg::idx_type'(b),
                                                active: newb, frame_ok: 1'b1, last: 1'b0});
                  end
               end
               base += len;
            end
            cur_words = new_words;
            rsp.frame_ok = 1'b1;
         end
         byte_count = '0;
         expected_words.push_back(rsp);
      end
   endfunction

   // Sender: bursts of random length separated by random gaps.
   req_word_type cur_item;
   int           burst_left = 0;
   int           gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_frame_word(cur_item);
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_bus.valid <= 1'b0;
            end else if (frame_items.size() != 0) begin
               cur_item = frame_items.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.mode <= cur_item.mode;
               req_bus.data_byte <= cur_item.data_byte;
               req_bus.now_ms <= cur_item.now_ms;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 16);
               end
               burst_left--;
               if (burst_left == 0) begin
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: stalls on a rotating pattern that is reloaded now and then,
   // sometimes with all ones so that long stretches run without stalls.
   logic [15:0]             ready_pattern = 16'hFFFF;
   int                      pattern_age = 0;
   rbfcd_pkg::rsp_word_type got_word;
   rbfcd_pkg::rsp_word_type want_word;

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got_word.kind = rsp_bus.kind;
            got_word.button_index = rsp_bus.button_index;
            got_word.active = rsp_bus.active;
            got_word.frame_ok = rsp_bus.frame_ok;
            got_word.last = rsp_bus.last;
            if (expected_words.size() == 0) begin
               report_mismatch($sformatf("unexpected word %p", got_word));
            end else begin
               want_word = expected_words.pop_front();
               if (got_word.kind !== want_word.kind)
                  report_mismatch($sformatf("kind %b, want %b", got_word.kind, want_word.kind));
               if (got_word.button_index !== want_word.button_index)
                  report_mismatch($sformatf("button_index %0d, want %0d",
                                            got_word.button_index, want_word.button_index));
               if (got_word.active !== want_word.active)
                  report_mismatch($sformatf("active %b, want %b (button %0d)",
                                            got_word.active, want_word.active,
                                            want_word.button_index));
               if (got_word.frame_ok !== want_word.frame_ok)
                  report_mismatch($sformatf("frame_ok %b, want %b",
                                            got_word.frame_ok, want_word.frame_ok));
               if (got_word.last !== want_word.last)
                  report_mismatch($sformatf("last %b, want %b", got_word.last, want_word.last));
            end
         end
         if (pattern_age == 0) begin
            pattern_age = $urandom_range(16, 96);
            ready_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF
                                                         : (16'($urandom) | 16'h0001);
         end else begin
            pattern_age--;
         end
         rsp_bus.ready <= ready_pattern[0];
         ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic push_byte(input logic [7:0] value);
      frame_items.push_back('{mode: rbfcd_pkg::ModeByte, data_byte: value, now_ms: $urandom});
   endtask

   task automatic push_end(input rbfcd_pkg::ms_type now);
      frame_items.push_back('{mode: rbfcd_pkg::ModeEnd, data_byte: 8'($urandom), now_ms: now});
   endtask

   // Waits until the sender has nothing left and every expected word has come,
   // then gives a trailing byte word time to finish inside the block.
   task automatic settle();
      do @(negedge clock);
      while (frame_items.size() != 0 || req_bus.valid || expected_words.size() != 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_debounce(input rbfcd_pkg::debounce_type value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.data <= value;
      do @(posedge clock);
      while (!(csr_bus.valid && csr_bus.ready));
      debounce_ms = value;
      csr_bus.valid <= 1'b0;
   endtask

   // Mostly good frames whose content drifts from the previous one, with some
   // short and long frames mixed in. Time steps cluster around the debounce window.
   task automatic fill_random_phase(input int budget);
      int         added;
      int         nbytes;
      int         pick;
      logic [7:0] b;
      added = 0;
      @(negedge clock);
      while (added < budget) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            nbytes = 6;
         end else if (pick == 7) begin
            nbytes = $urandom_range(0, 5);
         end else begin
            nbytes = $urandom_range(7, 18);
         end
         for (int i = 0; i < nbytes; i++) begin
            if (i < 6 && $urandom_range(0, 1) == 1) begin
               b = last_frame[i] ^ (8'h01 << $urandom_range(0, 7));
            end else begin
               b = 8'($urandom);
            end
            if (i < 6) begin
               last_frame[i] = b;
            end
            push_byte(b);
         end
         pick = $urandom_range(0, 7);
         case (pick)
            0: wall_ms = wall_ms + rbfcd_pkg::ms_type'(debounce_ms);
            1: wall_ms = wall_ms + rbfcd_pkg::ms_type'(debounce_ms) - 1;
            2: wall_ms = $urandom;
            default: wall_ms = wall_ms + $urandom_range(0, 2 * int'(debounce_ms) + 4);
         endcase
         push_end(wall_ms);
         added += nbytes + 1;
      end
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.mode = rbfcd_pkg::ModeByte;
      req_bus.data_byte = '0;
      req_bus.now_ms = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.data = '0;
      reset = 1'b1;

      debounce_ms = rbfcd_pkg::DebounceReset;
      byte_count = '0;
      wall_ms = '0;
      for (int i = 0; i < rbfcd_pkg::NumWords; i++) begin
         new_words[i] = '0;
         cur_words[i] = '0;
      end
      for (int i = 0; i < rbfcd_pkg::NumButtons; i++) begin
         toggle_ms[i] = '0;
      end
      for (int i = 0; i < 6; i++) begin
         last_frame[i] = '0;
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Every button presses at once under the reset debounce value.
      for (int i = 0; i < 6; i++) push_byte(8'hFF);
      push_end(rbfcd_pkg::ms_type'(100));
      // All released only 19 ms later: debounce holds every button.
      for (int i = 0; i < 6; i++) push_byte(8'h00);
      push_end(rbfcd_pkg::ms_type'(119));
      // An empty frame, then a short one that leaves a partly written frame behind.
      push_end(rbfcd_pkg::ms_type'(200));
      push_byte(8'hAA);
      push_byte(8'h55);
      push_end(rbfcd_pkg::ms_type'(300));
      // Mixed pattern at the top of the time range.
      push_byte(8'hFF);
      push_byte(8'h0F);
      push_byte(8'h00);
      push_byte(8'hF0);
      push_byte(8'h3F);
      push_byte(8'hC0);
      push_end(rbfcd_pkg::ms_type'(32'hFFFF_FFFF));
      last_frame = '{8'hFF, 8'h0F, 8'h00, 8'hF0, 8'h3F, 8'hC0};
      wall_ms = 32'hFFFF_FFFF;
      settle();

      write_debounce('0);
      fill_random_phase(22);
      settle();
      write_debounce(16'hFFFF);
      fill_random_phase(22);
      settle();
      write_debounce(rbfcd_pkg::debounce_type'($urandom_range(1, 200)));
      fill_random_phase(22);
      settle();
      write_debounce(rbfcd_pkg::DebounceReset);
      fill_random_phase(22);
      settle();

      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/rbfcd_pkg.sv
rtl/rbfcd_req_if.sv
rtl/rbfcd_rsp_if.sv
rtl/rbfcd_csr_if.sv
rtl/remote_button_frame_change_detect.sv
test/testbench.sv
